// File: rtl/multi_channel_message_ring_buffer_core_defines.svh
// assertion macros for the message ring buffer core
`ifndef MULTI_CHANNEL_MESSAGE_RING_BUFFER_CORE_DEFINES_SVH
`define MULTI_CHANNEL_MESSAGE_RING_BUFFER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MCMRB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MCMRB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCMRB_ASSERT(label, prop, msg)
`define MCMRB_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: rtl/mcmrb_pkg.sv
// types and constants of the message ring buffer core
package mcmrb_pkg;
	localparam int NUM_BUFFERS_DEF = 4;
	localparam int SLOTS_DEF = 8;
	localparam int MSG_BYTES = 32;

	typedef enum logic [3:0] {
		ACT_START_WRITE   = 4'd0,
		ACT_WRITE_BYTE    = 4'd1,
		ACT_STOP_WRITE    = 4'd2,
		ACT_ADVANCE_WRITE = 4'd3,
		ACT_START_READ    = 4'd4,
		ACT_READ_BYTE     = 4'd5,
		ACT_STOP_READ     = 4'd6,
		ACT_ADVANCE_READ  = 4'd7,
		ACT_CLEAR_OVERRUN = 4'd8,
		ACT_DELETE_ALL    = 4'd9,
		ACT_STATUS        = 4'd10
	} action_t;

	typedef struct packed {
		logic [3:0] action;
		logic [1:0] buffer_select;
		logic [7:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic       success;
		logic [7:0] read_byte;
		logic [5:0] message_length;
		logic [3:0] message_count;
		logic       is_empty;
		logic       is_full;
		logic       overrun;
		logic       end_of_message;
		logic       head_valid;
	} out_item_t;
endpackage

// File: rtl/multi_channel_message_ring_buffer_core.sv
// top level of the multi channel message ring buffer core
// usage:
// the input channel carries one action transaction (action, buffer_select,
// write_data); the output channel returns exactly one status transaction
// for each accepted action, in order.
// an action is accepted into the request register, executed in ST_EXEC
// and its status is registered in ST_REPORT, from which out_valid rises.
// read_byte uses the registered read of the byte ram.
// delete_all walks the selected ring one slot per cycle in ST_DEL, which
// lies between ST_EXEC and ST_REPORT.
// only one action is handled at a time: the next one is accepted once the
// last has passed the execute step and the status step.
// in_stall stays high while an action is in flight; a result waiting on a
// stalled receiver is held in the output register, one more action may be
// accepted and waits before execution until that result leaves.
// reset clears all ring indices, overrun flags and slot marks; message
// bytes are not cleared, no byte is ever read before it was written.
`include "multi_channel_message_ring_buffer_core_defines.svh"
module multi_channel_message_ring_buffer_core #(
	parameter int NUM_BUFFERS = mcmrb_pkg::NUM_BUFFERS_DEF,
	parameter int SLOTS = mcmrb_pkg::SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mcmrb_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mcmrb_pkg::out_item_t out_item
);
	import mcmrb_pkg::*;

	localparam int NSL = NUM_BUFFERS * SLOTS;
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BIW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int SW = (NSL > 1) ? $clog2(NSL) : 1;
	localparam int DEPTH = NSL * MSG_BYTES;
	localparam int AW = $clog2(DEPTH);
	localparam int DEL_MAX = 2 * SLOTS + 2;
	localparam int KW = $clog2(DEL_MAX + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DEL, ST_REPORT} state_t;

	state_t state_q;
	in_item_t req_s1;
	logic sel_ok_s1;
	logic ok_q;
	logic rd_pend_q;
	logic [KW-1:0] k_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [IW-1:0] wi_q [NUM_BUFFERS];
	logic [IW-1:0] ri_q [NUM_BUFFERS];
	logic          ovr_q [NUM_BUFFERS];
	logic          rd_q [NSL];
	logic          wr_q [NSL];
	logic          vl_q [NSL];
	logic [5:0]    len_q [NSL];
	logic [5:0]    pos_q [NSL];

	logic [BIW-1:0] b;
	logic [IW-1:0] wi, ri, nx, ri_adv;
	logic [SW-1:0] ws, rs, nxs, hs;
	logic [IW:0] span, cnt;
	logic full, eom, can_adv;
	logic wb_ok, rb_ok, exec_go, exec_ok, exec_rd;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0] ram_rdata;

	function automatic logic [SW-1:0] slot_of(input logic [BIW-1:0] bb,
			input logic [IW-1:0] ii);
		return SW'(int'(bb) * SLOTS + int'(ii));
	endfunction

	function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] ii);
		return (int'(ii) == SLOTS - 1) ? '0 : IW'(int'(ii) + 1);
	endfunction

	always_comb begin
		b = BIW'(req_s1.buffer_select);
		wi = wi_q[b];
		ri = ri_q[b];
		nx = inc_idx(wi);
		ws = slot_of(b, wi);
		rs = slot_of(b, ri);
		nxs = slot_of(b, nx);
		if (wi >= ri) begin
			span = (IW+1)'(wi) - (IW+1)'(ri);
		end else begin
			span = (IW+1)'(int'(wi) + SLOTS - int'(ri));
		end
		cnt = span + (IW+1)'(vl_q[rs]);
		if (cnt != '0 && !vl_q[ws]) begin
			cnt = cnt - 1'b1;
		end
		full = (ri == nx) || vl_q[nxs] || ovr_q[b];
		eom = !rd_q[rs] || (pos_q[rs] >= len_q[rs]);
		can_adv = !((wi == ri) || vl_q[rs] || rd_q[rs]);
		ri_adv = can_adv ? inc_idx(ri) : ri;
		hs = slot_of(b, ri_adv);
		wb_ok = wr_q[ws] && (pos_q[ws] < MSG_BYTES);
		rb_ok = !eom && vl_q[rs] && rd_q[rs] && (pos_q[rs] < MSG_BYTES);
		exec_go = (state_q == ST_EXEC) && !(out_valid_q && out_stall);
		ram_we = exec_go && sel_ok_s1 && (req_s1.action == ACT_WRITE_BYTE) && wb_ok;
		exec_rd = sel_ok_s1 && (req_s1.action == ACT_READ_BYTE) && rb_ok;
		exec_ok = 1'b0;
		if (sel_ok_s1) begin
			unique case (req_s1.action)
				ACT_START_WRITE:   exec_ok = !ovr_q[b] && !rd_q[ws] && !vl_q[ws];
				ACT_WRITE_BYTE:    exec_ok = wb_ok;
				ACT_STOP_WRITE:    exec_ok = wr_q[ws];
				ACT_ADVANCE_WRITE: exec_ok = !full && !wr_q[ws] && vl_q[ws];
				ACT_START_READ:    exec_ok = !wr_q[rs] && vl_q[rs];
				ACT_READ_BYTE:     exec_ok = rb_ok;
				ACT_STOP_READ:     exec_ok = rd_q[rs];
				ACT_ADVANCE_READ:  exec_ok = can_adv;
				ACT_CLEAR_OVERRUN: exec_ok = ovr_q[b];
				ACT_DELETE_ALL:    exec_ok = 1'b1;
				ACT_STATUS:        exec_ok = 1'b1;
				default:           exec_ok = 1'b0;
			endcase
		end
		ram_waddr = AW'(int'(ws) * MSG_BYTES + int'(pos_q[ws]));
		ram_raddr = AW'(int'(rs) * MSG_BYTES + int'(pos_q[rs]));
	end

	mcmrb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_bytes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req_s1.write_data),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_s1 <= '0;
			sel_ok_s1 <= 1'b0;
			ok_q <= 1'b0;
			rd_pend_q <= 1'b0;
			k_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				wi_q[i] <= '0;
				ri_q[i] <= '0;
				ovr_q[i] <= 1'b0;
			end
			for (int i = 0; i < NSL; i++) begin
				rd_q[i] <= 1'b0;
				wr_q[i] <= 1'b0;
				vl_q[i] <= 1'b0;
				len_q[i] <= '0;
				pos_q[i] <= '0;
			end
		end else begin
			out_valid_q <= (state_q == ST_REPORT) || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						req_s1 <= in_item;
						sel_ok_s1 <= (int'(in_item.buffer_select) < NUM_BUFFERS);
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						ok_q <= exec_ok;
						rd_pend_q <= exec_rd;
						k_q <= '0;
						state_q <= (sel_ok_s1 && (req_s1.action == ACT_DELETE_ALL))
							? ST_DEL : ST_REPORT;
						if (sel_ok_s1) begin
							unique case (req_s1.action)
								ACT_START_WRITE: begin
									if (exec_ok) begin
										wr_q[ws] <= 1'b1;
										pos_q[ws] <= '0;
										len_q[ws] <= '0;
									end
								end
								ACT_WRITE_BYTE: begin
									if (ram_we) begin
										pos_q[ws] <= pos_q[ws] + 1'b1;
										len_q[ws] <= len_q[ws] + 1'b1;
									end
								end
								ACT_STOP_WRITE: begin
									if (wr_q[ws]) begin
										wr_q[ws] <= 1'b0;
										vl_q[ws] <= 1'b1;
									end
								end
								ACT_ADVANCE_WRITE: begin
									if (full) begin
										ovr_q[b] <= 1'b1;
									end else if (!wr_q[ws] && vl_q[ws]) begin
										wi_q[b] <= nx;
									end
								end
								ACT_START_READ: begin
									if (!wr_q[rs] && vl_q[rs]) begin
										rd_q[rs] <= 1'b1;
										pos_q[rs] <= '0;
									end
								end
								ACT_READ_BYTE: begin
									if (rb_ok) begin
										pos_q[rs] <= pos_q[rs] + 1'b1;
									end
								end
								ACT_STOP_READ: begin
									if (rd_q[rs]) begin
										rd_q[rs] <= 1'b0;
										vl_q[rs] <= 1'b0;
										pos_q[rs] <= '0;
										len_q[rs] <= '0;
									end
								end
								ACT_ADVANCE_READ: begin
									if (can_adv) begin
										ri_q[b] <= ri_adv;
									end
								end
								ACT_CLEAR_OVERRUN: begin
									ovr_q[b] <= 1'b0;
								end
								default: begin
								end
							endcase
						end
					end
				end
				ST_DEL: begin
					if (cnt != '0 && int'(k_q) < DEL_MAX) begin
						ri_q[b] <= ri_adv;
						vl_q[hs] <= 1'b0;
						pos_q[hs] <= '0;
						len_q[hs] <= '0;
						rd_q[hs] <= 1'b0;
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					state_q <= ST_IDLE;
					if (sel_ok_s1) begin
						out_q.success <= ok_q;
						out_q.read_byte <= rd_pend_q ? ram_rdata : 8'd0;
						out_q.message_length <= (vl_q[rs] && rd_q[rs]) ? len_q[rs] : 6'd0;
						out_q.message_count <= 4'(cnt);
						out_q.is_empty <= (cnt == '0);
						out_q.is_full <= full;
						out_q.overrun <= ovr_q[b];
						out_q.end_of_message <= eom;
						out_q.head_valid <= vl_q[rs];
					end else begin
						out_q <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	`MCMRB_ASSERT(a_no_accept_busy, (state_q != ST_IDLE) |-> in_stall, "accept while busy")
	`MCMRB_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_item)), "stalled result changed")
	`MCMRB_ASSERT(a_del_bound, (state_q == ST_DEL) |-> (int'(k_q) <= DEL_MAX), "delete overrun")
	`MCMRB_ASSERT(a_report_then_result, (state_q == ST_REPORT) |=> out_valid, "result missing")
endmodule

// File: rtl/mcmrb_ram.sv
// generic single write port ram with registered read
module mcmrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: verif/tb_multi_channel_message_ring_buffer_core.sv
// testbench for the multi channel message ring buffer core: directed and random actions
`timescale 1ns / 100ps
module tb_multi_channel_message_ring_buffer_core;
	import mcmrb_pkg::*;

	localparam int NBUF = NUM_BUFFERS_DEF;
	localparam int NSLOT = SLOTS_DEF;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;

	multi_channel_message_ring_buffer_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	// ring state mirror
	logic [2:0] wr_idx [NBUF];
	logic [2:0] rd_idx [NBUF];
	logic ovr [NBUF];
	logic s_rd [NBUF][NSLOT];
	logic s_wr [NBUF][NSLOT];
	logic s_vld [NBUF][NSLOT];
	logic [5:0] s_len [NBUF][NSLOT];
	logic [5:0] s_pos [NBUF][NSLOT];
	logic [7:0] msg_mem [NBUF][NSLOT][MSG_BYTES];

	out_item_t status_q [$];
	int errors;
	int idle_cycles;
	bit rx_idle_en;
	bit tx_idle_en;
	bit hold_rx;

	function automatic int ring_count(int b);
		int n;
		n = (int'(wr_idx[b]) + NSLOT - int'(rd_idx[b])) % NSLOT;
		n += s_vld[b][rd_idx[b]];
		if (n > 0 && !s_vld[b][wr_idx[b]])
			n -= 1;
		return n;
	endfunction

	function automatic bit ring_full(int b);
		logic [2:0] nx;
		nx = wr_idx[b] + 3'd1;
		return rd_idx[b] == nx || s_vld[b][nx] || ovr[b];
	endfunction

	function automatic bit try_advance_read(int b);
		logic [2:0] r;
		r = rd_idx[b];
		if (wr_idx[b] == r || s_vld[b][r] || s_rd[b][r])
			return 0;
		rd_idx[b] = r + 3'd1;
		return 1;
	endfunction

	function automatic bit at_eom(int b);
		logic [2:0] r;
		r = rd_idx[b];
		if (!s_rd[b][r])
			return 1;
		return s_pos[b][r] >= s_len[b][r];
	endfunction

	function automatic out_item_t apply_action(in_item_t it);
		out_item_t o;
		int b, n;
		logic [2:0] w, r;
		bit ok;
		logic [7:0] rbyte;
		b = it.buffer_select;
		w = wr_idx[b];
		r = rd_idx[b];
		ok = 0;
		rbyte = '0;
		case (it.action)
			ACT_START_WRITE: if (!ovr[b] && !s_rd[b][w] && !s_vld[b][w]) begin
				s_wr[b][w] = 1; s_pos[b][w] = 0; s_len[b][w] = 0; ok = 1;
			end
			ACT_WRITE_BYTE: if (s_wr[b][w] && s_pos[b][w] < MSG_BYTES) begin
				msg_mem[b][w][s_pos[b][w]] = it.write_data;
				s_pos[b][w]++; s_len[b][w]++; ok = 1;
			end
			ACT_STOP_WRITE: if (s_wr[b][w]) begin
				s_wr[b][w] = 0; s_vld[b][w] = 1; ok = 1;
			end
			ACT_ADVANCE_WRITE: begin
				if (ring_full(b))
					ovr[b] = 1;
				else if (!s_wr[b][w] && s_vld[b][w]) begin
					wr_idx[b] = w + 3'd1; ok = 1;
				end
			end
			ACT_START_READ: if (!s_wr[b][r] && s_vld[b][r]) begin
				s_rd[b][r] = 1; s_pos[b][r] = 0; ok = 1;
			end
			ACT_READ_BYTE: if (!at_eom(b) && s_vld[b][r] && s_rd[b][r]
					&& s_pos[b][r] < MSG_BYTES) begin
				rbyte = msg_mem[b][r][s_pos[b][r]];
				s_pos[b][r]++; ok = 1;
			end
			ACT_STOP_READ: if (s_rd[b][r]) begin
				s_rd[b][r] = 0; s_vld[b][r] = 0; s_pos[b][r] = 0; s_len[b][r] = 0;
				ok = 1;
			end
			ACT_ADVANCE_READ: ok = try_advance_read(b);
			ACT_CLEAR_OVERRUN: begin
				ok = ovr[b]; ovr[b] = 0;
			end
			ACT_DELETE_ALL: begin
				for (int k = 0; k < 2 * NSLOT + 2 && ring_count(b) != 0; k++) begin
					void'(try_advance_read(b));
					s_vld[b][rd_idx[b]] = 0; s_pos[b][rd_idx[b]] = 0;
					s_len[b][rd_idx[b]] = 0; s_rd[b][rd_idx[b]] = 0;
				end
				ok = 1;
			end
			ACT_STATUS: ok = 1;
			default: ok = 0;
		endcase
		r = rd_idx[b];
		n = ring_count(b);
		o.success = ok;
		o.read_byte = rbyte;
		o.message_length = (s_vld[b][r] && s_rd[b][r]) ? s_len[b][r] : 6'd0;
		o.message_count = n[3:0];
		o.is_empty = n == 0;
		o.is_full = ring_full(b);
		o.overrun = ovr[b];
		o.end_of_message = at_eom(b);
		o.head_valid = s_vld[b][r];
		return o;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	task automatic send_action(action_t a, int b, logic [7:0] d = 8'h00);
		in_item_t it;
		int gap;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		it.action = a;
		it.buffer_select = b[1:0];
		it.write_data = d;
		in_item <= it;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		status_q.push_back(apply_action(it));
		@(negedge clk);
	endtask

	task automatic send_raw(logic [3:0] a, int b, logic [7:0] d);
		send_action(action_t'(a), b, d);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		@(negedge clk);
		while (status_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_message(int b, int len);
		send_action(ACT_START_WRITE, b);
		repeat (len) send_action(ACT_WRITE_BYTE, b, 8'($urandom));
		send_action(ACT_STOP_WRITE, b);
		send_action(ACT_ADVANCE_WRITE, b);
	endtask

	task automatic read_message(int b, int len);
		send_action(ACT_START_READ, b);
		repeat (len) send_action(ACT_READ_BYTE, b);
		send_action(ACT_STOP_READ, b);
		send_action(ACT_ADVANCE_READ, b);
	endtask

	task automatic test_directed();
		send_action(ACT_STATUS, 0);
		send_action(ACT_READ_BYTE, 0);
		send_action(ACT_START_WRITE, 1);
		send_action(ACT_WRITE_BYTE, 1, 8'hff);
		send_action(ACT_WRITE_BYTE, 1, 8'h00);
		send_action(ACT_WRITE_BYTE, 1, 8'ha5);
		send_action(ACT_STOP_WRITE, 1);
		send_action(ACT_ADVANCE_WRITE, 1);
		send_action(ACT_START_READ, 1);
		send_action(ACT_READ_BYTE, 1);
		send_action(ACT_READ_BYTE, 1);
		send_action(ACT_READ_BYTE, 1);
		send_action(ACT_READ_BYTE, 1);
		send_action(ACT_STOP_READ, 1);
		send_action(ACT_ADVANCE_READ, 1);
		send_action(ACT_CLEAR_OVERRUN, 1);
		send_raw(4'd11, 2, 8'h5a);
		send_raw(4'd15, 3, 8'h00);
		send_action(ACT_DELETE_ALL, 3);
	endtask

	// fill one ring past capacity, overflow a message, then clear
	task automatic test_overrun();
		send_action(ACT_START_WRITE, 2);
		repeat (MSG_BYTES + 2) send_action(ACT_WRITE_BYTE, 2, 8'($urandom));
		send_action(ACT_STOP_WRITE, 2);
		send_action(ACT_ADVANCE_WRITE, 2);
		repeat (NSLOT) write_message(2, 1);
		send_action(ACT_START_WRITE, 2);
		send_action(ACT_CLEAR_OVERRUN, 2);
		send_action(ACT_CLEAR_OVERRUN, 2);
		read_message(2, MSG_BYTES + 1);
		send_action(ACT_DELETE_ALL, 2);
		send_action(ACT_STATUS, 2);
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_rx = 1;
		repeat (12) send_action(ACT_STATUS, $urandom_range(0, 3));
		wait_drained();
	endtask

	task automatic test_random(int items);
		int b, sel, len;
		int sent;
		sent = 0;
		while (sent < items) begin
			b = $urandom_range(0, 3);
			sel = $urandom_range(0, 9);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MSG_BYTES + 1)
				: $urandom_range(0, 4);
			if (sel < 4) begin
				write_message(b, len);
				sent += len + 3;
			end else if (sel < 8) begin
				read_message(b, len + 1);
				sent += len + 4;
			end else begin
				send_raw(4'($urandom_range(0, 15)), b, 8'($urandom));
				sent++;
			end
		end
	endtask

	// receiver stalls, with one long hold-off when requested
	initial begin
		int burst;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_stall <= 1;
				repeat (60) @(negedge clk);
				out_stall <= 0;
				hold_rx = 0;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 18);
				out_stall <= 1;
				repeat (burst) @(negedge clk);
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		out_item_t exp_st;
		if (arst_n && out_valid && !out_stall) begin
			if (status_q.size() == 0) begin
				$display("%0t unexpected transaction %p", $time, out_item);
				errors++;
			end else begin
				exp_st = status_q.pop_front();
				if (out_item !== exp_st) begin
					$display("%0t mismatch expected %p actual %p", $time, exp_st, out_item);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		hold_rx = 0;
		rx_idle_en = 0;
		tx_idle_en = 0;
		in_valid = 0;
		in_item = '0;
		arst_n = 0;
		for (int b = 0; b < NBUF; b++) begin
			wr_idx[b] = 0; rd_idx[b] = 0; ovr[b] = 0;
			for (int s = 0; s < NSLOT; s++) begin
				s_rd[b][s] = 0; s_wr[b][s] = 0; s_vld[b][s] = 0;
				s_len[b][s] = 0; s_pos[b][s] = 0;
			end
		end
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		rx_idle_en = 1;
		tx_idle_en = 1;
		test_overrun();
		test_backpressure();
		test_random(1100);
		wait_drained();
		rx_idle_en = 0;
		tx_idle_en = 0;
		test_random(360);
		wait_drained();
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl
rtl/mcmrb_pkg.sv
rtl/mcmrb_ram.sv
rtl/multi_channel_message_ring_buffer_core.sv
verif/tb_multi_channel_message_ring_buffer_core.sv
